// ----- rtl/gn3d_pkg.sv -----
// Shared constants and helpers for the 3D gradient noise core.
`default_nettype none
package gn3d_pkg;
    localparam logic [31:0] HMUL_X   = 32'd374761393;
    localparam logic [31:0] HMUL_Y   = 32'd668265263;
    localparam logic [31:0] HMUL_Z   = 32'd1445635377;
    localparam logic [31:0] HMUL_MIX = 32'd1274126177;
    localparam int          NOISE_W  = 20;
    localparam int          DOT_W    = 19;

    // Improved-Perlin gradient dot product, selected by the low hash nibble.
    function automatic logic signed [DOT_W-1:0] grad_dot(
        input logic [3:0]         g,
        input logic signed [17:0] x,
        input logic signed [17:0] y,
        input logic signed [17:0] z
    );
        logic signed [DOT_W-1:0] u;
        logic signed [DOT_W-1:0] v;
        u = (g < 4'd8) ? DOT_W'(x) : DOT_W'(y);
        if (g < 4'd4)
            v = DOT_W'(y);
        else if (g == 4'd12 || g == 4'd14)
            v = DOT_W'(x);
        else
            v = DOT_W'(z);
        if (g[0])
            u = -u;
        if (g[1])
            v = -v;
        return u + v;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/gradient_noise_3d_core.sv -----
// Top level of the 3D gradient noise core.
`default_nettype none
// Pipelined 3D improved-Perlin gradient noise: one point (signed fixed point with FRAC_BITS
// fraction bits) in per cycle, one Q4.16 noise beat out per cycle, while the output is not
// stalled. The pipe is 12 register stages deep. Hash multiplies and the fade polynomial share
// the front stages (hash products at stage 1, the mix product at stage 3), the corner dot
// products follow, and the x, y and z blends each take a multiply stage and an add stage. The
// whole pipe advances whenever the output is not stalled or holds no valid beat, so a full
// rate of one beat per clock is sustained when the output does not stall; a stalled output
// beat freezes every stage and stalls the input.
module gradient_noise_3d_core #(
    parameter int FRAC_BITS    = 16,
    parameter int LATTICE_BITS = 8
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire signed [31:0] coord_x,
    input  wire signed [31:0] coord_y,
    input  wire signed [31:0] coord_z,
    output logic              out_valid,
    input  wire               out_stall,
    output logic signed [19:0] noise_value
);
    localparam int DEPTH     = 12;
    localparam int TAPS      = 5;
    localparam int CW        = LATTICE_BITS + 1;
    localparam int DW        = gn3d_pkg::DOT_W;

    logic             adv;
    logic [DEPTH-1:0] v_reg;

    assign adv       = !v_reg[DEPTH-1] || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = v_reg[DEPTH-1];

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
    end

    // Stage 0: split coordinates into lattice cell and Q0.16 fraction
    logic [CW-1:0] cell_reg [3];
    logic [15:0]   t_reg [3][TAPS];
    logic [31:0]   cin [3];
    assign cin[0] = coord_x;
    assign cin[1] = coord_y;
    assign cin[2] = coord_z;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [15:0] tnext;
        logic [63:0] sx;
        logic [63:0] fr;
        assign sx = {{32{cin[a][31]}}, cin[a]};
        assign fr = sx & ((64'd1 << FRAC_BITS) - 64'd1);
        assign tnext = (FRAC_BITS >= 16) ? 16'(fr >> (FRAC_BITS - 16))
                                         : 16'(fr << (16 - FRAC_BITS));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cell_reg[a]  <= {1'b0, LATTICE_BITS'(sx >> FRAC_BITS)};
                t_reg[a][0] <= tnext;
                for (int s = 1; s < TAPS; s++)
                    t_reg[a][s] <= t_reg[a][s-1];
            end
        end

        // Fade: p at stage 1 -> q; then three t*f multiplies, stages 2..4
        logic [35:0] p_reg;
        logic [32:0] f1_reg;
        logic [32:0] f2_reg;
        logic [32:0] f3_reg;
        logic [16:0] fade_reg [TAPS];
        logic [35:0] p_next;
        logic [35:0] t0;
        assign t0 = {20'd0, t_reg[a][0]};
        // p = 6t^2 - 15t*2^16 + 10*2^32, always positive and below 2^36
        assign p_next = 36'd6 * t0 * t0 + 36'hA_0000_0000 - 36'd15 * (t0 << 16);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_reg  <= p_next;
                f1_reg <= 33'((50'(t_reg[a][1]) * 50'(p_reg[35:16])) >> 16);
                f2_reg <= 33'((50'(t_reg[a][2]) * 50'(f1_reg)) >> 16);
                f3_reg <= 33'((50'(t_reg[a][3]) * 50'(f2_reg)) >> 16);
                fade_reg[0] <= 17'(f3_reg);
                for (int s = 1; s < TAPS; s++)
                    fade_reg[s] <= fade_reg[s-1];
            end
        end
    end

    // Corner hashes: stage 1 products, 2 sum, 3 mix product, 4 final xorshift
    logic [31:0] hp_reg [8][3];
    logic [31:0] hs_reg [8];
    logic [31:0] hm_reg [8];
    logic [3:0]  hg_reg [8];
    logic signed [DW-1:0] dot_reg [8];

    for (genvar c = 0; c < 8; c++) begin : g_corner
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] hx;
        logic [31:0] hmx;
        assign cx = 32'(cell_reg[0]) + 32'(c & 1);
        assign cy = 32'(cell_reg[1]) + 32'((c >> 1) & 1);
        assign cz = 32'(cell_reg[2]) + 32'((c >> 2) & 1);
        assign hx  = hs_reg[c] ^ (hs_reg[c] >> 13);
        assign hmx = hm_reg[c] ^ (hm_reg[c] >> 16);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hp_reg[c][0] <= cx * gn3d_pkg::HMUL_X;
                hp_reg[c][1] <= cy * gn3d_pkg::HMUL_Y;
                hp_reg[c][2] <= cz * gn3d_pkg::HMUL_Z;
                hs_reg[c] <= hp_reg[c][0] + hp_reg[c][1] + hp_reg[c][2];
                hm_reg[c] <= hx * gn3d_pkg::HMUL_MIX;
                hg_reg[c] <= hmx[3:0];
                // Stage 5: dot product with the corner offsets
                dot_reg[c] <= gn3d_pkg::grad_dot(hg_reg[c],
                    (c & 1) != 0 ? $signed({2'b0, t_reg[0][4]}) - 18'sd65536
                                 : $signed({2'b0, t_reg[0][4]}),
                    (c & 2) != 0 ? $signed({2'b0, t_reg[1][4]}) - 18'sd65536
                                 : $signed({2'b0, t_reg[1][4]}),
                    (c & 4) != 0 ? $signed({2'b0, t_reg[2][4]}) - 18'sd65536
                                 : $signed({2'b0, t_reg[2][4]}));
            end
        end
    end

    // Blends: multiply stage then add stage (floor shift is an arithmetic shift)
    // x blend at stages 6-7, y at 8-9, z at 10-11
    logic signed [DW-1:0] bx_a_reg [4];
    logic signed [37:0]   bx_m_reg [4];
    logic signed [DW-1:0] bx_reg [4];
    logic signed [DW-1:0] by_a_reg [2];
    logic signed [37:0]   by_m_reg [2];
    logic signed [DW-1:0] by_reg [2];
    logic signed [DW-1:0] bz_a_reg;
    logic signed [37:0]   bz_m_reg;
    logic signed [19:0]   res_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                bx_a_reg[k] <= dot_reg[2*k];
                bx_m_reg[k] <= $signed({1'b0, g_axis[0].fade_reg[0]})
                    * 38'(dot_reg[2*k+1] - dot_reg[2*k]);
                bx_reg[k] <= bx_a_reg[k] + DW'(bx_m_reg[k] >>> 16);
            end
            for (int k = 0; k < 2; k++)
            begin
                by_a_reg[k] <= bx_reg[2*k];
                by_m_reg[k] <= $signed({1'b0, g_axis[1].fade_reg[2]})
                    * 38'(bx_reg[2*k+1] - bx_reg[2*k]);
                by_reg[k] <= by_a_reg[k] + DW'(by_m_reg[k] >>> 16);
            end
            bz_a_reg <= by_reg[0];
            bz_m_reg <= $signed({1'b0, g_axis[2].fade_reg[4]}) * 38'(by_reg[1] - by_reg[0]);
            res_reg  <= 20'(bz_a_reg) + 20'(bz_m_reg >>> 16);
        end
    end

    assign noise_value = res_reg;

`ifndef NO_ASSERTIONS
    // A stalled output beat holds while the pipe is frozen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(noise_value))
        else $error("output beat lost under stall");
    // Input is stalled only when the output holds a stalled beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("spurious input stall");
    // An accepted beat enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_valid |=> v_reg[0])
        else $error("accepted beat not captured");
`endif
endmodule
`default_nettype wire

// ----- verif/gradient_noise_3d_core_tb.sv -----
// Self-checking testbench for the 3D gradient noise core.
`default_nettype none
module gradient_noise_3d_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 16;
    localparam int LATTICE_BITS = 8;
    localparam int PIPE_DEPTH   = 12;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [19:0] noise_value;

    // expected noise beats, oldest first
    logic signed [19:0] noise_queue[$];
    int                 error_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_cycles;

    gradient_noise_3d_core #(
        .FRAC_BITS    (FRAC_BITS),
        .LATTICE_BITS (LATTICE_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // floor index and Q0.16 fraction of one coordinate
    function automatic void split_axis(input logic [31:0] raw, output logic [31:0] lat,
                                       output longint frac);
        logic [63:0] wide;
        logic [63:0] fr;
        wide = {{32{raw[31]}}, raw};
        lat  = 32'((wide >> FRAC_BITS) & ((64'd1 << LATTICE_BITS) - 1));
        fr   = wide & ((64'd1 << FRAC_BITS) - 1);
        if (FRAC_BITS >= 16)
            fr = fr >> (FRAC_BITS - 16);
        else
            fr = fr << (16 - FRAC_BITS);
        frac = longint'(fr & 64'hFFFF);
    endfunction

    function automatic logic [31:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy,
                                                 input logic [31:0] cz);
        logic [31:0] h;
        h = cx * gn3d_pkg::HMUL_X + cy * gn3d_pkg::HMUL_Y + cz * gn3d_pkg::HMUL_Z;
        h = (h ^ (h >> 13)) * gn3d_pkg::HMUL_MIX;
        return h ^ (h >> 16);
    endfunction

    // quintic fade on Q0.16
    function automatic longint fade_curve(input longint t);
        logic [63:0] ut;
        logic [63:0] p;
        logic [63:0] f;
        ut = 64'(t);
        p  = 64'd6 * ut * ut + 64'd10 * (64'd1 << 32) - 64'd15 * ut * 64'd65536;
        f  = p >> 16;
        f  = (ut * f) >> 16;
        f  = (ut * f) >> 16;
        f  = (ut * f) >> 16;
        return longint'(f);
    endfunction

    function automatic longint mix_q16(input longint f, input longint a, input longint b);
        longint prod;
        prod = f * (b - a);
        return a + (prod >>> 16);
    endfunction

    function automatic longint corner_dot(input logic [3:0] g, input longint x,
                                          input longint y, input longint z);
        longint u;
        longint v;
        u = (g < 8) ? x : y;
        if (g < 4)
            v = y;
        else if (g == 12 || g == 14)
            v = x;
        else
            v = z;
        if (g[0])
            u = -u;
        if (g[1])
            v = -v;
        return u + v;
    endfunction

    function automatic logic signed [19:0] predict_noise(input logic [31:0] px,
                                                          input logic [31:0] py,
                                                          input logic [31:0] pz);
        logic [31:0] lx, ly, lz;
        logic [31:0] h;
        longint      tx, ty, tz;
        longint      fx, fy, fz;
        longint      dx[2], dy[2], dz[2];
        longint      dots[8];
        longint      xa, xb, xc, xd, ya, yb, r;
        split_axis(px, lx, tx);
        split_axis(py, ly, ty);
        split_axis(pz, lz, tz);
        fx = fade_curve(tx);
        fy = fade_curve(ty);
        fz = fade_curve(tz);
        dx[0] = tx; dx[1] = tx - 65536;
        dy[0] = ty; dy[1] = ty - 65536;
        dz[0] = tz; dz[1] = tz - 65536;
        // corner bit0 = x+1, bit1 = y+1, bit2 = z+1
        for (int i = 0; i < 8; i++)
        begin
            h = lattice_hash(lx + i[0], ly + i[1], lz + i[2]);
            dots[i] = corner_dot(h[3:0], dx[i[0]], dy[i[1]], dz[i[2]]);
        end
        xa = mix_q16(fx, dots[0], dots[1]);
        xb = mix_q16(fx, dots[2], dots[3]);
        xc = mix_q16(fx, dots[4], dots[5]);
        xd = mix_q16(fx, dots[6], dots[7]);
        ya = mix_q16(fy, xa, xb);
        yb = mix_q16(fy, xc, xd);
        r  = mix_q16(fz, ya, yb);
        return r[19:0];
    endfunction

    // send one point, with random idle cycles before it
    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= px;
        coord_y  <= py;
        coord_z  <= pz;
        noise_queue.push_back(predict_noise(px, py, pz));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return {16'($signed($urandom_range(6)) - 3), 16'($urandom())};
            2: return {$urandom_range(1) ? 16'h00FF : 16'hFF00, 16'($urandom())};
            3: return {16'($urandom()), $urandom_range(1) ? 16'h0000 : 16'hFFFF};
            default: return {16'($urandom_range(511)), 16'($urandom())};
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (noise_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [31:0] edge_vals[10];
        edge_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h0001_0000, 32'hFFFF_0000, 32'h00FF_FFFF, 32'h00FF_8000,
                      32'h0000_8000, 32'hFF00_0001};
        for (int i = 0; i < 10; i++)
            send_point(edge_vals[i], edge_vals[(i + 3) % 10], edge_vals[(i + 7) % 10]);
        // upper lattice corner on each axis
        send_point(32'h00FF_4000, 32'h0000_4000, 32'h0000_4000);
        send_point(32'h0000_4000, 32'h00FF_C000, 32'h0000_4000);
        send_point(32'h0000_4000, 32'h0000_4000, 32'h00FF_2000);
        // negative coordinates, floor toward minus infinity
        send_point(32'hFFFF_8000, 32'hFFFE_0001, 32'hFF80_1234);
        send_point(32'h8000_0001, 32'h8000_FFFF, 32'hFFFF_FFFE);
        wait_drained();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 60;
        for (int i = 0; i < 80; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        wait_drained();
    endtask

    // receiver stall, with a long counted hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (noise_queue.size() == 0)
            begin
                $display("%0t: unexpected noise beat, expected none, actual %0d",
                         $time, noise_value);
                error_count++;
            end
            else
            begin
                if (noise_value !== noise_queue[0])
                begin
                    $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                             $time, noise_queue[0], noise_value);
                    error_count++;
                end
                void'(noise_queue.pop_front());
            end
        end
    end

    initial
    begin
        #20ms;
        $display("gradient_noise_3d_core_tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        coord_x       = '0;
        coord_y       = '0;
        coord_z       = '0;
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(330, 26, 71);
        test_random(330, 71, 26);
        test_random(260, 0, 0);
        test_backpressure();
        if (noise_queue.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("gradient_noise_3d_core_tb: done, clean");
        else
            $display("gradient_noise_3d_core_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/gn3d_pkg.sv
rtl/gradient_noise_3d_core.sv
verif/gradient_noise_3d_core_tb.sv
